FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by query_string_splitter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: rtl/qss_pkg.sv
// ----------------------------------------------------------------------------
// qss_pkg
// types and constants of the query string splitter
// ----------------------------------------------------------------------------
package qss_pkg;

  localparam int MAX_QUERY_LEN_DEF = 4096;

  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_EQ  = 8'h3D;

  localparam int NAME_START_W  = 12;
  localparam int LEN_W         = 13;
  localparam int PAIR_COUNT_W  = 12;

  typedef enum logic [1:0] {
    KIND_PAIR  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [NAME_START_W-1:0]   name_start;
    logic [LEN_W-1:0]          name_len;
    logic [LEN_W-1:0]          value_start;
    logic [LEN_W-1:0]          value_len;
    logic                      has_value;
    logic [PAIR_COUNT_W-1:0]   pair_count;
    logic                      last;
  } res_t;

  function automatic res_t make_res(
    input kind_t                   kind,
    input logic [NAME_START_W-1:0] ns,
    input logic [LEN_W-1:0]        nl,
    input logic [LEN_W-1:0]        vs,
    input logic [LEN_W-1:0]        vl,
    input logic                    hv,
    input logic [PAIR_COUNT_W-1:0] pc
  );
    res_t r;
    r.kind        = kind;
    r.name_start  = ns;
    r.name_len    = nl;
    r.value_start = vs;
    r.value_len   = vl;
    r.has_value   = hv;
    r.pair_count  = pc;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/qss_if.sv
// ----------------------------------------------------------------------------
// qss_if
// valid/ready channels for query bytes and pair results
// ----------------------------------------------------------------------------
interface qss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       end_of_query;

  modport source (output valid, char_code, has_char, end_of_query, input ready);
  modport sink (input valid, char_code, has_char, end_of_query, output ready);
endinterface

interface qss_out_if;
  logic                                   valid;
  logic                                   ready;
  qss_pkg::kind_t                         kind;
  logic [qss_pkg::NAME_START_W-1:0]       name_start;
  logic [qss_pkg::LEN_W-1:0]              name_len;
  logic [qss_pkg::LEN_W-1:0]              value_start;
  logic [qss_pkg::LEN_W-1:0]              value_len;
  logic                                   has_value;
  logic [qss_pkg::PAIR_COUNT_W-1:0]       pair_count;
  logic                                   last;

  modport source (output valid, kind, name_start, name_len, value_start, value_len,
                  has_value, pair_count, last, input ready);
  modport sink (input valid, kind, name_start, name_len, value_start, value_len,
                has_value, pair_count, last, output ready);
endinterface

FILE: rtl/query_string_splitter.sv
// ----------------------------------------------------------------------------
// query_string_splitter
// splits a uri query string, one byte per item, into name/value pair results
// the first result of an item shows on out_ch in the cycle after it is taken
// throughput: one item per cycle while out_ch is ready; an item with two results holds input
// the two-entry result buffer sets the rate: input waits until it is empty or draining
// reset: synchronous active-low rst_n empties the buffer and clears the parser state
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module query_string_splitter #(
  parameter int MAX_QUERY_LEN = qss_pkg::MAX_QUERY_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  qss_in_if.sink     in_ch,
  qss_out_if.source  out_ch
);

  // offsets run from 0 up to and including MAX_QUERY_LEN
  localparam int PW = $clog2(MAX_QUERY_LEN + 1);
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_QUERY_LEN);

  // parser state
  logic [PW-1:0] pos_r, pos_nxt;      // offset of the next byte
  logic [PW-1:0] seg_r, seg_nxt;      // offset where the current name begins
  logic [PW-1:0] held_r, held_nxt;    // name length while a value is open
  logic          inv_r, inv_nxt;      // a value is open
  logic [PW-1:0] pairs_r, pairs_nxt;  // pairs emitted in this query
  logic          err_r, err_nxt;      // empty-name error seen, rest ignored

  // result buffer: entry 0 is always the one on the output
  qss_pkg::res_t buf_r [2];
  qss_pkg::res_t buf_nxt [2];
  logic [1:0]    cnt_r, cnt_nxt;

  // results made by the item on the input this cycle
  qss_pkg::res_t res [2];
  logic [1:0]    k;

  logic in_fire;
  logic out_fire;

  assign out_fire    = out_ch.valid && out_ch.ready;
  // take a new item once the buffer is empty or drains this cycle
  assign in_ch.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // per-item parse: byte compares against '&' and '=' and offset add/subtract arithmetic
  always_comb begin
    logic [PW-1:0] vs;
    logic          proc;
    vs        = seg_r + held_r + PW'(1);
    proc      = in_ch.has_char && !err_r && (pos_r < MAX_POS);
    pos_nxt   = pos_r;
    seg_nxt   = seg_r;
    held_nxt  = held_r;
    inv_nxt   = inv_r;
    pairs_nxt = pairs_r;
    err_nxt   = err_r;
    k         = 2'd0;
    res[0]    = '0;
    res[1]    = '0;

    if (proc) begin
      if (inv_r) begin
        // '&' closes the open value; '=' inside a value is data
        if (in_ch.char_code == qss_pkg::CH_AMP) begin
          pairs_nxt = pairs_r + PW'(1);
          res[0] = qss_pkg::make_res(qss_pkg::KIND_PAIR, 12'(seg_r), 13'(held_r),
                                     13'(vs), 13'(pos_r - vs), 1'b1, 12'(pairs_nxt));
          k        = 2'd1;
          inv_nxt  = 1'b0;
          held_nxt = '0;
          seg_nxt  = pos_r + PW'(1);
        end
      end else if (in_ch.char_code == qss_pkg::CH_AMP) begin
        // name with no value; repeated ampersand gives nothing
        if (pos_r != seg_r) begin
          pairs_nxt = pairs_r + PW'(1);
          res[0] = qss_pkg::make_res(qss_pkg::KIND_PAIR, 12'(seg_r), 13'(pos_r - seg_r),
                                     '0, '0, 1'b0, 12'(pairs_nxt));
          k = 2'd1;
        end
        seg_nxt = pos_r + PW'(1);
      end else if (in_ch.char_code == qss_pkg::CH_EQ) begin
        if (pos_r == seg_r) begin
          // empty name: report and ignore the rest of the query
          res[0] = qss_pkg::make_res(qss_pkg::KIND_ERROR, 12'(pos_r), '0, '0, '0,
                                     1'b0, 12'(pairs_r));
          k       = 2'd1;
          err_nxt = 1'b1;
        end else begin
          held_nxt = pos_r - seg_r;
          inv_nxt  = 1'b1;
        end
      end
      pos_nxt = pos_r + PW'(1);
    end

    if (in_ch.end_of_query) begin
      // a value still open at the end is a pair; it always lands in slot 0
      // the value may have been opened by this same item's byte
      if (inv_nxt && !err_nxt) begin
        vs        = seg_nxt + held_nxt + PW'(1);
        pairs_nxt = pairs_nxt + PW'(1);
        res[0] = qss_pkg::make_res(qss_pkg::KIND_PAIR, 12'(seg_nxt), 13'(held_nxt),
                                   13'(vs), 13'(pos_nxt - vs), 1'b1, 12'(pairs_nxt));
        k = 2'd1;
      end
      res[k[0]] = qss_pkg::make_res(qss_pkg::KIND_DONE, '0, '0, '0, '0, 1'b0,
                                    12'(pairs_nxt));
      k = k + 2'd1;
      // start over for the next query
      pos_nxt   = '0;
      seg_nxt   = '0;
      held_nxt  = '0;
      inv_nxt   = 1'b0;
      pairs_nxt = '0;
      err_nxt   = 1'b0;
    end

    // mark the last result of this item
    unique case (k)
      2'd1:    res[0].last = 1'b1;
      2'd2:    res[1].last = 1'b1;
      default: ;
    endcase
  end

  // result buffer load and drain
  always_comb begin
    buf_nxt[0] = buf_r[0];
    buf_nxt[1] = buf_r[1];
    cnt_nxt    = cnt_r;
    priority if (in_fire) begin
      // buffer is empty or emptying, so the new results replace it
      buf_nxt[0] = res[0];
      buf_nxt[1] = res[1];
      cnt_nxt    = k;
    end else if (out_fire) begin
      buf_nxt[0] = buf_r[1];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      seg_r   <= '0;
      held_r  <= '0;
      inv_r   <= 1'b0;
      pairs_r <= '0;
      err_r   <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      if (in_fire) begin
        pos_r   <= pos_nxt;
        seg_r   <= seg_nxt;
        held_r  <= held_nxt;
        inv_r   <= inv_nxt;
        pairs_r <= pairs_nxt;
        err_r   <= err_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    buf_r[0] <= buf_nxt[0];
    buf_r[1] <= buf_nxt[1];
  end

  // output drive
  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.kind        = buf_r[0].kind;
  assign out_ch.name_start  = buf_r[0].name_start;
  assign out_ch.name_len    = buf_r[0].name_len;
  assign out_ch.value_start = buf_r[0].value_start;
  assign out_ch.value_len   = buf_r[0].value_len;
  assign out_ch.has_value   = buf_r[0].has_value;
  assign out_ch.pair_count  = buf_r[0].pair_count;
  assign out_ch.last        = buf_r[0].last;

  // checks
  `ASSERT_CLK(a_end_clears_state, (in_fire && in_ch.end_of_query) |=> (pos_r == '0 && pairs_r == '0 && !err_r && !inv_r))
  `ASSERT_CLK(a_two_held_order, (cnt_r == 2'd2) |-> (!buf_r[0].last && buf_r[1].last))
  `ASSERT_CLK(a_one_held_last, (cnt_r == 2'd1) |-> buf_r[0].last)
  `ASSERT_CLK(a_pos_bound, (pos_r <= MAX_POS) && (seg_r <= pos_r))
  `ASSERT_ALWAYS(a_no_overfill, (!rst_n) || (cnt_r != 2'd3))

endmodule
